/* rtl/core/modswitch_sub_mul_add_acc_defines.svh */
// Assertion macros for the modulus-switch datapath checkers.
// Uses i_clk and i_rst_n of the module that includes it.
`ifndef MODSWITCH_SUB_MUL_ADD_ACC_DEFINES_SVH
`define MODSWITCH_SUB_MUL_ADD_ACC_DEFINES_SVH

// plain property, checked out of reset
`define MSSMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication from an antecedent to a consequent in the same cycle
`define MSSMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mssma_pkg.sv */
// Shared types, register indexes and modular helpers for the modulus-switch datapath.
// No dependencies.
package mssma_pkg;

    localparam int WORD_BITS    = 64;
    localparam int HALF_BITS    = 32;
    localparam int LATENCY      = 15;
    localparam int CFG_IDX_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO_LO = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO_HI = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FACTOR   = 4'd3;

    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [2*WORD_BITS-1:0] t_dword;

    typedef struct packed {
        t_word q;
        t_word ratio_lo;
        t_word ratio_hi;
        t_word factor;
    } t_cfg;

    function automatic t_word mod_sub(t_word a, t_word b, t_word q);
        t_word d;
        d = a - b;
        if (a < b) begin
            d = d + q;
        end
        return d;
    endfunction

    function automatic t_word mod_add(t_word a, t_word b, t_word q);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[WORD_BITS] || (s[WORD_BITS-1:0] >= q)) begin
            return s[WORD_BITS-1:0] - q;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_dword barrett_fix(t_dword r, t_word q);
        if (r >= {{WORD_BITS{1'b0}}, q}) begin
            return r - {{WORD_BITS{1'b0}}, q};
        end
        return r;
    endfunction

endpackage

/* rtl/core/modswitch_sub_mul_add_acc.sv */
// Top level of the modulus-switch subtract, multiply, add and accumulate datapath.
// Depends on mssma_pkg and mssma_lane.
//
// Usage:
//   Input channel: drive the eight coefficients and raise i_start; the item is
//   taken at a clock edge where i_start is high and o_busy is low. o_busy is
//   high only while reset is held, so a new item may enter every cycle.
//   Result channel: o_valid strobes for one cycle with o_sum_a and o_sum_b.
//   The receiver cannot stall; results are never held back.
//   Timing: o_sum_a, o_sum_b and o_valid come out of the last registers of their
//   pipelines together. Throughput one item per cycle. Depth is set by
//   three chained two-stage 32x32 partial-product multipliers (coefficient
//   product, ratio products, estimate times q), the subtract, the carry and
//   estimate sums, the remainder, three correction stages and two additions.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (modulus, ratio low, ratio high, switch factor); write only while idle.
//   Reset: clears the valid pipeline and loads the register reset values;
//   items in flight are dropped.
module modswitch_sub_mul_add_acc #(
    parameter int COEFF_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_cfg_we,
    input  logic [mssma_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  mssma_pkg::t_word                     i_cfg_data,
    input  logic [COEFF_BITS-1:0]                i_poly_a,
    input  logic [COEFF_BITS-1:0]                i_poly_last_a,
    input  logic [COEFF_BITS-1:0]                i_poly_b,
    input  logic [COEFF_BITS-1:0]                i_poly_last_b,
    input  logic [COEFF_BITS-1:0]                i_cipher_a,
    input  logic [COEFF_BITS-1:0]                i_cipher_b,
    input  logic [COEFF_BITS-1:0]                i_accum_a,
    input  logic [COEFF_BITS-1:0]                i_accum_b,
    output logic                                 o_valid,
    output logic [COEFF_BITS-1:0]                o_sum_a,
    output logic [COEFF_BITS-1:0]                o_sum_b
);
    import mssma_pkg::*;

    localparam t_word COEFF_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - COEFF_BITS);

    t_word r_modulus, r_ratio_lo, r_ratio_hi, r_factor;
    logic [LATENCY-1:0] r_vld;
    logic  w_accept;
    t_cfg  w_cfg;
    t_word w_sum_a, w_sum_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= t_word'(2);
            r_ratio_lo <= '0;
            r_ratio_hi <= '0;
            r_factor   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_RATIO_LO: r_ratio_lo <= i_cfg_data;
                CFG_RATIO_HI: r_ratio_hi <= i_cfg_data;
                CFG_FACTOR:   r_factor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy   = !i_rst_n;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    assign w_cfg.q        = r_modulus & COEFF_MASK;
    assign w_cfg.ratio_lo = r_ratio_lo;
    assign w_cfg.ratio_hi = r_ratio_hi;
    assign w_cfg.factor   = r_factor & COEFF_MASK;

    mssma_lane #(.COEFF_BITS(COEFF_BITS)) u_lane_a (
        .i_clk(i_clk), .i_cfg(w_cfg),
        .i_poly(t_word'(i_poly_a)), .i_poly_last(t_word'(i_poly_last_a)),
        .i_cipher(t_word'(i_cipher_a)), .i_accum(t_word'(i_accum_a)),
        .o_sum(w_sum_a)
    );

    mssma_lane #(.COEFF_BITS(COEFF_BITS)) u_lane_b (
        .i_clk(i_clk), .i_cfg(w_cfg),
        .i_poly(t_word'(i_poly_b)), .i_poly_last(t_word'(i_poly_last_b)),
        .i_cipher(t_word'(i_cipher_b)), .i_accum(t_word'(i_accum_b)),
        .o_sum(w_sum_b)
    );

    assign o_valid = r_vld[LATENCY-1];
    assign o_sum_a = w_sum_a[COEFF_BITS-1:0];
    assign o_sum_b = w_sum_b[COEFF_BITS-1:0];

endmodule

/* rtl/core/mssma_mul.sv */
// Two-stage 64x64 to 128-bit multiplier from four registered 32x32 partial products.
// Depends on mssma_pkg.
module mssma_mul (
    input  logic           i_clk,
    input  mssma_pkg::t_word  i_a,
    input  mssma_pkg::t_word  i_b,
    output mssma_pkg::t_dword o_prod
);
    import mssma_pkg::*;

    t_word  r_p00, r_p01, r_p10, r_p11;
    t_dword r_prod;

    always_ff @(posedge i_clk) begin
        r_p00  <= {{HALF_BITS{1'b0}}, i_a[HALF_BITS-1:0]} * {{HALF_BITS{1'b0}}, i_b[HALF_BITS-1:0]};
        r_p01  <= {{HALF_BITS{1'b0}}, i_a[HALF_BITS-1:0]} *
                  {{HALF_BITS{1'b0}}, i_b[WORD_BITS-1:HALF_BITS]};
        r_p10  <= {{HALF_BITS{1'b0}}, i_a[WORD_BITS-1:HALF_BITS]} *
                  {{HALF_BITS{1'b0}}, i_b[HALF_BITS-1:0]};
        r_p11  <= {{HALF_BITS{1'b0}}, i_a[WORD_BITS-1:HALF_BITS]} *
                  {{HALF_BITS{1'b0}}, i_b[WORD_BITS-1:HALF_BITS]};
        r_prod <= {r_p11, r_p00}
                + {{HALF_BITS{1'b0}}, r_p01, {HALF_BITS{1'b0}}}
                + {{HALF_BITS{1'b0}}, r_p10, {HALF_BITS{1'b0}}};
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/mssma_lane.sv */
// One ciphertext component: subtract, Barrett multiply, add, accumulate; 15 stages.
// Depends on mssma_pkg and mssma_mul.
module mssma_lane #(
    parameter int COEFF_BITS = 64
) (
    input  logic             i_clk,
    input  mssma_pkg::t_cfg  i_cfg,
    input  mssma_pkg::t_word i_poly,
    input  mssma_pkg::t_word i_poly_last,
    input  mssma_pkg::t_word i_cipher,
    input  mssma_pkg::t_word i_accum,
    output mssma_pkg::t_word o_sum
);
    import mssma_pkg::*;

    localparam t_word COEFF_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - COEFF_BITS);

    t_word  r_d, r_enc1, r_acc1;
    t_dword w_x, w_pb, w_pc, w_pd, w_pe, w_pf;
    t_word  r_t1, r_t3, r_dh, r_dl, r_el, r_est;
    t_dword r_xd [6];
    t_word  r_ed [12];
    t_word  r_ad [13];
    t_dword r_r0, r_r1, r_r2, r_r3;
    t_word  r_s, r_sum;
    logic [WORD_BITS:0] w_t1, w_c2;

    mssma_mul u_mul_x (.i_clk(i_clk), .i_a(r_d), .i_b(i_cfg.factor), .o_prod(w_x));
    mssma_mul u_mul_b (.i_clk(i_clk), .i_a(w_x[WORD_BITS-1:0]), .i_b(i_cfg.ratio_lo),
                       .o_prod(w_pb));
    mssma_mul u_mul_c (.i_clk(i_clk), .i_a(w_x[WORD_BITS-1:0]), .i_b(i_cfg.ratio_hi),
                       .o_prod(w_pc));
    mssma_mul u_mul_d (.i_clk(i_clk), .i_a(w_x[2*WORD_BITS-1:WORD_BITS]), .i_b(i_cfg.ratio_lo),
                       .o_prod(w_pd));
    mssma_mul u_mul_e (.i_clk(i_clk), .i_a(w_x[2*WORD_BITS-1:WORD_BITS]), .i_b(i_cfg.ratio_hi),
                       .o_prod(w_pe));
    mssma_mul u_mul_f (.i_clk(i_clk), .i_a(r_est), .i_b(i_cfg.q), .o_prod(w_pf));

    assign w_t1 = {1'b0, w_pc[WORD_BITS-1:0]} + {1'b0, w_pb[2*WORD_BITS-1:WORD_BITS]};
    assign w_c2 = {1'b0, r_t1} + {1'b0, r_dl};

    always_ff @(posedge i_clk) begin
        r_d    <= mod_sub(i_poly, i_poly_last, i_cfg.q) & COEFF_MASK;
        r_enc1 <= i_cipher;
        r_acc1 <= i_accum;

        r_t1 <= w_t1[WORD_BITS-1:0];
        r_t3 <= w_pc[2*WORD_BITS-1:WORD_BITS] + {{(WORD_BITS-1){1'b0}}, w_t1[WORD_BITS]};
        r_dh <= w_pd[2*WORD_BITS-1:WORD_BITS];
        r_dl <= w_pd[WORD_BITS-1:0];
        r_el <= w_pe[WORD_BITS-1:0];

        r_est <= r_el + r_t3 + r_dh + {{(WORD_BITS-1){1'b0}}, w_c2[WORD_BITS]};

        r_xd[0] <= w_x;
        for (int k = 1; k < 6; k++) begin
            r_xd[k] <= r_xd[k-1];
        end
        r_ed[0] <= r_enc1;
        for (int k = 1; k < 12; k++) begin
            r_ed[k] <= r_ed[k-1];
        end
        r_ad[0] <= r_acc1;
        for (int k = 1; k < 13; k++) begin
            r_ad[k] <= r_ad[k-1];
        end

        r_r0 <= r_xd[5] - w_pf;
        r_r1 <= barrett_fix(r_r0, i_cfg.q);
        r_r2 <= barrett_fix(r_r1, i_cfg.q);
        r_r3 <= barrett_fix(r_r2, i_cfg.q);

        r_s   <= mod_add(r_r3[WORD_BITS-1:0] & COEFF_MASK, r_ed[11], i_cfg.q) & COEFF_MASK;
        r_sum <= mod_add(r_ad[12], r_s, i_cfg.q) & COEFF_MASK;
    end

    assign o_sum = r_sum;

endmodule

/* rtl/core/mssma_chk.sv */
// Port-level checks of latency and zero propagation for the modulus-switch datapath.
// Depends on mssma_pkg and modswitch_sub_mul_add_acc_defines.svh; bound to the top level.
`include "modswitch_sub_mul_add_acc_defines.svh"

module mssma_chk #(
    parameter int COEFF_BITS = 64
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic [COEFF_BITS-1:0] i_poly_a,
    input logic [COEFF_BITS-1:0] i_poly_last_a,
    input logic [COEFF_BITS-1:0] i_poly_b,
    input logic [COEFF_BITS-1:0] i_poly_last_b,
    input logic [COEFF_BITS-1:0] i_cipher_a,
    input logic [COEFF_BITS-1:0] i_cipher_b,
    input logic [COEFF_BITS-1:0] i_accum_a,
    input logic [COEFF_BITS-1:0] i_accum_b,
    input logic                  o_valid,
    input logic [COEFF_BITS-1:0] o_sum_a,
    input logic [COEFF_BITS-1:0] o_sum_b
);
    import mssma_pkg::*;

    `MSSMA_ASSERT(a_latency, (o_valid == $past(i_start && !o_busy, 15)), "result strobe out of step with accepted item")
    `MSSMA_ASSERT_IMP(a_zero_a, o_valid && $past(i_start && !o_busy && (i_poly_a == i_poly_last_a) && (i_cipher_a == '0) && (i_accum_a == '0), 15), o_sum_a == '0, "zero item gave nonzero sum_a")
    `MSSMA_ASSERT_IMP(a_zero_b, o_valid && $past(i_start && !o_busy && (i_poly_b == i_poly_last_b) && (i_cipher_b == '0) && (i_accum_b == '0), 15), o_sum_b == '0, "zero item gave nonzero sum_b")

endmodule

bind modswitch_sub_mul_add_acc mssma_chk #(.COEFF_BITS(COEFF_BITS)) u_mssma_chk (.*);
